>>> rtl/mma_pkg.sv
package mma_pkg;

	// Block sizing
	localparam int CHANNELS     = 5;
	localparam int WINDOW_DEPTH = 20;
	localparam int SAMPLE_BITS  = 12;

	// Field widths
	localparam int CH_W  = 3;
	localparam int LVL_W = 12;
	localparam int POS_W = $clog2(WINDOW_DEPTH + 1);
	localparam int PCT_W = 7;

	// Window memory: one row of WINDOW_DEPTH entries per channel
	localparam int RAM_DEPTH = CHANNELS * WINDOW_DEPTH;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	// Arithmetic widths
	localparam int PCT_MAX = 100;
	localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int PROD_W  = LVL_W + $clog2(PCT_MAX + 1);
	localparam int DIVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int DVS_W   = (LVL_W > POS_W) ? LVL_W : POS_W;
	localparam int DCNT_W  = $clog2(DIVD_W + 1);

	// Stream payload widths
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = CH_W;
	localparam int OUT_FIELD_W = 2 * LVL_W + POS_W + PCT_W;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = CH_W;

	// Highest valid channel code
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

	// Configuration registers
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_WET = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_DRY = 1'b1;
	localparam logic [LVL_W-1:0] WET_RESET = 12'd1450;
	localparam logic [LVL_W-1:0] DRY_RESET = 12'd2700;

endpackage

>>> rtl/mma_ram.sv
module mma_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 100
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/mma_div.sv
module mma_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mma_pkg::DIVD_W-1:0]  dividend,
	input  logic [mma_pkg::DVS_W-1:0]   divisor,
	output logic                        done,
	output logic [mma_pkg::DIVD_W-1:0]  quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [mma_pkg::DCNT_W-1:0]  cnt_q;
	logic [mma_pkg::DIVD_W-1:0]  quo_q;
	logic [mma_pkg::DVS_W-1:0]   rem_q;
	logic [mma_pkg::DVS_W-1:0]   dvs_q;
	logic [mma_pkg::DVS_W:0]     rem_sh;
	logic                        ge;
	logic [mma_pkg::DVS_W:0]     rem_nx;

	// Restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[mma_pkg::DIVD_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= mma_pkg::DCNT_W'(mma_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mma_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mma_pkg::DIVD_W-2:0], ge};
			rem_q <= rem_nx[mma_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/multichannel_moving_average_percent.sv
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | tuser: channel; tdata: sample
// m_       | out | m_tvalid/m_tready  | tuser: channel_out;
//          |     |                    | tdata: raw_out, mean_level, samples_used, percent
// cfg_     | in  | cfg_we             | cfg_addr: 0 wet_level, 1 dry_level; cfg_wdata
//
// s_tready returns in the cycle in which the result is loaded and m_tvalid
// rises, so a new request is not taken before the last result is loaded. The
// window row is read one entry per cycle, then the serial divider (19 quotient
// steps) runs once for the mean and once for the percentage map; equal levels
// skip the second run.
// s_tready is high only while the sequencer is idle; a request for a channel
// out of range is taken and dropped with no result.
// The result sits in an output register, so a stalled m_ side does not hold
// the next computation until that result has to be loaded.
// Reset clears write positions and window-full flags; the window memory
// needs no clearing since only written entries are read.
module multichannel_moving_average_percent (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [11:0] sample
	input  logic [mma_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [2:0] channel
	input  logic [mma_pkg::IN_TUSER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [11:0] raw_out, [23:12] mean_level, [28:24] samples_used, [35:29] percent
	output logic [mma_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [2:0] channel_out
	output logic [mma_pkg::OUT_TUSER_W-1:0]    m_tuser,
	input  logic                               cfg_we,
	input  logic [mma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mma_pkg::LVL_W-1:0]          cfg_wdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SUM    = 3'd1;
	localparam logic [2:0] ST_MDIV   = 3'd2;
	localparam logic [2:0] ST_MAP    = 3'd3;
	localparam logic [2:0] ST_PSTART = 3'd4;
	localparam logic [2:0] ST_PDIV   = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]                        state_q;
	logic [mma_pkg::LVL_W-1:0]         wet_q;
	logic [mma_pkg::LVL_W-1:0]         dry_q;
	logic [mma_pkg::POS_W-1:0]         wpos_q [mma_pkg::CHANNELS];
	logic                              full_q [mma_pkg::CHANNELS];

	logic [mma_pkg::CH_W-1:0]          ch_q;
	logic [mma_pkg::SAMPLE_BITS-1:0]   smp_q;
	logic [mma_pkg::ADDR_W-1:0]        base_q;
	logic [mma_pkg::POS_W-1:0]         cnt_q;
	logic [mma_pkg::POS_W-1:0]         idx_q;
	logic                              rd_pend_q;
	logic [mma_pkg::SUM_W-1:0]         sum_q;
	logic [mma_pkg::LVL_W-1:0]         mean_q;
	logic                              neg_q;
	logic [mma_pkg::PROD_W-1:0]        num_q;
	logic [mma_pkg::DVS_W-1:0]         den_q;
	logic [mma_pkg::PCT_W-1:0]         pct_q;

	logic                              m_tvalid_q;
	logic [mma_pkg::OUT_TDATA_W-1:0]   m_tdata_q;
	logic [mma_pkg::OUT_TUSER_W-1:0]   m_tuser_q;

	logic [mma_pkg::CH_W-1:0]          in_ch;
	logic [mma_pkg::SAMPLE_BITS-1:0]   in_smp;
	logic                              in_range;
	logic                              take;
	logic [mma_pkg::POS_W-1:0]         pos_raw;
	logic [mma_pkg::POS_W-1:0]         pos;
	logic [mma_pkg::POS_W-1:0]         pos_inc;
	logic [mma_pkg::POS_W-1:0]         cnt_new;
	logic [mma_pkg::ADDR_W-1:0]        base_new;
	logic                              rd_en;
	logic                              sum_done;
	logic [mma_pkg::ADDR_W-1:0]        raddr;
	logic [mma_pkg::SAMPLE_BITS-1:0]   rdata;
	logic                              div_start;
	logic [mma_pkg::DIVD_W-1:0]        div_dividend;
	logic [mma_pkg::DVS_W-1:0]         div_divisor;
	logic                              div_done;
	logic [mma_pkg::DIVD_W-1:0]        div_quo;
	logic [mma_pkg::LVL_W:0]           diff;
	logic [mma_pkg::LVL_W:0]           span;
	logic [mma_pkg::LVL_W-1:0]         diff_mag;
	logic [mma_pkg::LVL_W-1:0]         span_mag;
	logic [mma_pkg::PCT_W-1:0]         pct_calc;
	logic                              out_free;

	// Input decode and per-channel window position
	always_comb begin
		in_ch    = s_tuser[mma_pkg::CH_W-1:0];
		in_smp   = s_tdata[mma_pkg::SAMPLE_BITS-1:0];
		in_range = in_ch <= mma_pkg::CH_LAST;
		take     = s_tvalid && (state_q == ST_IDLE);
		pos_raw  = in_range ? wpos_q[in_ch] : '0;
		pos      = (pos_raw >= mma_pkg::POS_W'(mma_pkg::WINDOW_DEPTH)) ? '0 : pos_raw;
		pos_inc  = pos + 1'b1;
		cnt_new  = (in_range && full_q[in_ch]) ?
			mma_pkg::POS_W'(mma_pkg::WINDOW_DEPTH) : pos_inc;
		base_new = mma_pkg::ADDR_W'(in_ch * mma_pkg::WINDOW_DEPTH);
	end

	assign s_tready = (state_q == ST_IDLE);

	// Window read sweep
	assign rd_en    = idx_q != cnt_q;
	assign sum_done = !rd_en && !rd_pend_q;
	assign raddr    = base_q + mma_pkg::ADDR_W'(idx_q);

	mma_ram #(
		.WIDTH (mma_pkg::SAMPLE_BITS),
		.DEPTH (mma_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (take && in_range),
		.waddr (base_new + mma_pkg::ADDR_W'(pos)),
		.wdata (in_smp),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Shared divider: mean first, then the percentage map
	always_comb begin
		div_start = ((state_q == ST_SUM) && sum_done) || (state_q == ST_PSTART);
		if (state_q == ST_SUM) begin
			div_dividend = mma_pkg::DIVD_W'(sum_q);
			div_divisor  = mma_pkg::DVS_W'(cnt_q);
		end else begin
			div_dividend = mma_pkg::DIVD_W'(num_q);
			div_divisor  = den_q;
		end
	end

	mma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Signed offsets from the wet level, as sign and magnitude
	always_comb begin
		diff     = {1'b0, mean_q} - {1'b0, wet_q};
		span     = {1'b0, dry_q} - {1'b0, wet_q};
		diff_mag = diff[mma_pkg::LVL_W] ? mma_pkg::LVL_W'(-diff) : diff[mma_pkg::LVL_W-1:0];
		span_mag = span[mma_pkg::LVL_W] ? mma_pkg::LVL_W'(-span) : span[mma_pkg::LVL_W-1:0];
	end

	// 100 minus the signed quotient, clamped to 0..100
	always_comb begin
		if (neg_q) begin
			pct_calc = mma_pkg::PCT_W'(mma_pkg::PCT_MAX);
		end else if (div_quo > mma_pkg::DIVD_W'(mma_pkg::PCT_MAX)) begin
			pct_calc = '0;
		end else begin
			pct_calc = mma_pkg::PCT_W'(mma_pkg::PCT_MAX) - div_quo[mma_pkg::PCT_W-1:0];
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wet_q      <= mma_pkg::WET_RESET;
			dry_q      <= mma_pkg::DRY_RESET;
			idx_q      <= '0;
			rd_pend_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
				wpos_q[c] <= '0;
				full_q[c] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					mma_pkg::REG_WET: wet_q <= cfg_wdata;
					mma_pkg::REG_DRY: dry_q <= cfg_wdata;
					default: ;
				endcase
			end

			// Result valid: set on load, cleared once taken
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (take && in_range) begin
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						if (pos_inc == mma_pkg::POS_W'(mma_pkg::WINDOW_DEPTH)) begin
							wpos_q[in_ch] <= '0;
							full_q[in_ch] <= 1'b1;
						end else begin
							wpos_q[in_ch] <= pos_inc;
						end
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					rd_pend_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (sum_done) begin
						state_q <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						state_q <= ST_MAP;
					end
				end
				ST_MAP: begin
					state_q <= (wet_q == dry_q) ? ST_OUT : ST_PSTART;
				end
				ST_PSTART: begin
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (take && in_range) begin
			ch_q   <= in_ch;
			smp_q  <= in_smp;
			base_q <= base_new;
			cnt_q  <= cnt_new;
			sum_q  <= '0;
		end else if ((state_q == ST_SUM) && rd_pend_q) begin
			sum_q <= sum_q + mma_pkg::SUM_W'(rdata);
		end

		if ((state_q == ST_MDIV) && div_done) begin
			mean_q <= div_quo[mma_pkg::LVL_W-1:0];
		end

		if (state_q == ST_MAP) begin
			neg_q <= (diff[mma_pkg::LVL_W] != span[mma_pkg::LVL_W]);
			num_q <= mma_pkg::PROD_W'(diff_mag) * mma_pkg::PROD_W'(mma_pkg::PCT_MAX);
			den_q <= mma_pkg::DVS_W'(span_mag);
			pct_q <= '0;
		end else if ((state_q == ST_PDIV) && div_done) begin
			pct_q <= pct_calc;
		end

		if ((state_q == ST_OUT) && out_free) begin
			m_tuser_q <= ch_q;
			m_tdata_q <= {{(mma_pkg::OUT_TDATA_W - mma_pkg::OUT_FIELD_W){1'b0}},
				pct_q, cnt_q, mean_q, smp_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/mma_checker.sv
module mma_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [mma_pkg::IN_TUSER_W-1:0]     s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [mma_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic [mma_pkg::OUT_TUSER_W-1:0]    m_tuser
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A request on a valid channel keeps the block busy next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[mma_pkg::CH_W-1:0] <= mma_pkg::CH_LAST)
		|=> !s_tready)
		else $error("ready right after taking a request");

	// Sample count and percentage stay in range
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:24] != 5'd0) &&
		(m_tdata[28:24] <= mma_pkg::POS_W'(mma_pkg::WINDOW_DEPTH)) &&
		(m_tdata[35:29] <= mma_pkg::PCT_W'(mma_pkg::PCT_MAX)))
		else $error("result field out of range");

	// Results only for existing channels
	a_out_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[mma_pkg::CH_W-1:0] <= mma_pkg::CH_LAST)
		else $error("result for a channel that does not exist");

endmodule

bind multichannel_moving_average_percent mma_checker u_mma_checker (.*);

>>> tb/multichannel_moving_average_percent_tb.sv
module multichannel_moving_average_percent_tb;

	// Result fields, as they travel on the m_ side
	typedef struct packed {
		logic [mma_pkg::CH_W-1:0]  ch;
		logic [mma_pkg::LVL_W-1:0] raw;
		logic [mma_pkg::LVL_W-1:0] mean;
		logic [mma_pkg::POS_W-1:0] used;
		logic [mma_pkg::PCT_W-1:0] pct;
	} reading_t;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One row of the directed plan: a sample request or a level write
	typedef struct {
		row_kind_t   kind;
		int unsigned a;      // channel, or register index
		int unsigned b;      // sample, or level
		bit          typed;  // expected result given in the row
		int unsigned mean;
		int unsigned used;
		int unsigned pct;
	} plan_row_t;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 80;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 169;
	localparam int PLAN_LEN    = 25;
	localparam int PRINT_CAP   = 40;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [mma_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [mma_pkg::IN_TUSER_W-1:0]  s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [mma_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [mma_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic                            cfg_we = 1'b0;
	logic [mma_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [mma_pkg::LVL_W-1:0]       cfg_wdata = '0;

	// Shadow state of the filter
	logic [mma_pkg::LVL_W-1:0] win [mma_pkg::CHANNELS][mma_pkg::WINDOW_DEPTH];
	int unsigned               wpos [mma_pkg::CHANNELS];
	bit                        wfull [mma_pkg::CHANNELS];
	logic [mma_pkg::LVL_W-1:0] wet_lvl = mma_pkg::WET_RESET;
	logic [mma_pkg::LVL_W-1:0] dry_lvl = mma_pkg::DRY_RESET;

	reading_t    pending_readings [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          calm = 1'b0;
	int unsigned stall_left = 0;
	reading_t    seen;
	reading_t    oldest;

	plan_row_t plan [PLAN_LEN] = '{
		// first sample per channel, reset levels: mean is the sample
		'{ROW_SAMPLE, 0, 0,    1'b1, 0,    1, 100},
		'{ROW_SAMPLE, 1, 4095, 1'b1, 4095, 1, 0},
		'{ROW_SAMPLE, 2, 1450, 1'b1, 1450, 1, 100},
		'{ROW_SAMPLE, 3, 2700, 1'b1, 2700, 1, 0},
		'{ROW_SAMPLE, 4, 2075, 1'b1, 2075, 1, 50},
		// channels out of range: dropped, no result; then more samples on channels 0 and 1
		'{ROW_SAMPLE, 5, 123,  1'b1, 0, 0, 0},
		'{ROW_SAMPLE, 6, 2730, 1'b1, 0, 0, 0},
		'{ROW_SAMPLE, 7, 1365, 1'b1, 0, 0, 0},
		'{ROW_SAMPLE, 0, 4095, 1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 1, 2730, 1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 1, 1365, 1'b0, 0, 0, 0},
		// full-scale levels
		'{ROW_WRITE,  mma_pkg::REG_WET, 0,    1'b0, 0, 0, 0},
		'{ROW_WRITE,  mma_pkg::REG_DRY, 4095, 1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 2, 4095, 1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 3, 0,    1'b0, 0, 0, 0},
		// inverted levels
		'{ROW_WRITE,  mma_pkg::REG_WET, 4095, 1'b0, 0, 0, 0},
		'{ROW_WRITE,  mma_pkg::REG_DRY, 0,    1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 4, 0,    1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 4, 4095, 1'b0, 0, 0, 0},
		// equal levels at top, then at zero
		'{ROW_WRITE,  mma_pkg::REG_DRY, 4095, 1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 0, 1234, 1'b0, 0, 0, 0},
		'{ROW_WRITE,  mma_pkg::REG_WET, 0,    1'b0, 0, 0, 0},
		'{ROW_WRITE,  mma_pkg::REG_DRY, 0,    1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 2, 0,    1'b0, 0, 0, 0},
		'{ROW_SAMPLE, 3, 4095, 1'b0, 0, 0, 0}
	};

	multichannel_moving_average_percent DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what, got, want);
	endtask

	// Window update, truncated mean and calibrated percentage for one sample
	function automatic bit average_sample(input int unsigned ch,
			input logic [mma_pkg::LVL_W-1:0] smp, output reading_t r);
		int unsigned cnt;
		int unsigned sum;
		int          m;
		int          p;
		r = '0;
		if (ch >= mma_pkg::CHANNELS)
			return 1'b0;
		win[ch][wpos[ch]] = smp;
		cnt = wfull[ch] ? mma_pkg::WINDOW_DEPTH : wpos[ch] + 1;
		sum = 0;
		for (int i = 0; i < cnt; i++)
			sum += int'(win[ch][i]);
		m = sum / cnt;
		if (wet_lvl == dry_lvl) begin
			p = 0;
		end else begin
			// signed division, truncating toward zero
			p = (m - int'(wet_lvl)) * (-100) / (int'(dry_lvl) - int'(wet_lvl)) + 100;
			if (p < 0)
				p = 0;
			if (p > mma_pkg::PCT_MAX)
				p = mma_pkg::PCT_MAX;
		end
		wpos[ch]++;
		if (wpos[ch] >= mma_pkg::WINDOW_DEPTH) begin
			wpos[ch] = 0;
			wfull[ch] = 1'b1;
		end
		r.ch   = mma_pkg::CH_W'(ch);
		r.raw  = smp;
		r.mean = mma_pkg::LVL_W'(m);
		r.used = mma_pkg::POS_W'(cnt);
		r.pct  = mma_pkg::PCT_W'(p);
		return 1'b1;
	endfunction

	// Offer one request, with an optional idle burst ahead of it
	task automatic send_request(input int unsigned ch, input int unsigned smp, input bit typed,
			input reading_t want);
		reading_t r;
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mma_pkg::IN_TUSER_W'(ch);
		s_tdata  <= {{(mma_pkg::IN_TDATA_W - mma_pkg::LVL_W){1'b0}}, smp[mma_pkg::LVL_W-1:0]};
		do @(posedge clk); while (!s_tready);
		if (average_sample(ch, smp[mma_pkg::LVL_W-1:0], r))
			pending_readings.push_back(typed ? want : r);
	endtask

	// Level write, once all results are out and the block has settled
	task automatic write_level(input logic [mma_pkg::CFG_ADDR_W-1:0] idx,
			input logic [mma_pkg::LVL_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mma_pkg::REG_WET)
			wet_lvl = val;
		else
			dry_lvl = val;
	endtask

	// Sample mix: full range, rails, and values around the calibration points
	function automatic int unsigned pick_sample();
		int v;
		case ($urandom_range(0, 4))
			0, 1: v = int'($urandom_range(0, 4095));
			2: v = $urandom_range(0, 1) ? 4095 : 0;
			default: begin
				v = ($urandom_range(0, 1) ? int'(wet_lvl) : int'(dry_lvl)) +
					int'($urandom_range(0, 600)) - 300;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
			end
		endcase
		return unsigned'(v);
	endfunction

	// Receiver: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.ch   = m_tuser[mma_pkg::CH_W-1:0];
			seen.raw  = m_tdata[11:0];
			seen.mean = m_tdata[23:12];
			seen.used = m_tdata[28:24];
			seen.pct  = m_tdata[35:29];
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected result on channel", int'(seen.ch), -1);
			end else begin
				oldest = pending_readings.pop_front();
				if (seen.ch != oldest.ch)
					report_mismatch("channel_out", int'(seen.ch), int'(oldest.ch));
				if (seen.raw != oldest.raw)
					report_mismatch("raw_out", int'(seen.raw), int'(oldest.raw));
				if (seen.mean != oldest.mean)
					report_mismatch("mean_level", int'(seen.mean), int'(oldest.mean));
				if (seen.used != oldest.used)
					report_mismatch("samples_used", int'(seen.used), int'(oldest.used));
				if (seen.pct != oldest.pct)
					report_mismatch("percent", int'(seen.pct), int'(oldest.pct));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("multichannel_moving_average_percent_tb: errors");
			$finish;
		end
	end

	initial begin
		reading_t    want;
		int unsigned ch;
		int unsigned w;
		int unsigned d;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				write_level(mma_pkg::CFG_ADDR_W'(plan[i].a), mma_pkg::LVL_W'(plan[i].b));
			end else begin
				want.ch   = mma_pkg::CH_W'(plan[i].a);
				want.raw  = mma_pkg::LVL_W'(plan[i].b);
				want.mean = mma_pkg::LVL_W'(plan[i].mean);
				want.used = mma_pkg::POS_W'(plan[i].used);
				want.pct  = mma_pkg::PCT_W'(plan[i].pct);
				send_request(plan[i].a, plan[i].b, plan[i].typed, want);
			end
		end

		// Random phases, each under its own calibration
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin w = 32'(mma_pkg::WET_RESET); d = 32'(mma_pkg::DRY_RESET); end
				1: begin w = 0; d = 4095; end
				2: begin w = 4095; d = 0; end
				4: begin w = $urandom_range(0, 4095); d = w; end
				6: begin w = 4095; d = 4095; end
				default: begin w = $urandom_range(0, 4095); d = $urandom_range(0, 4095); end
			endcase
			write_level(mma_pkg::REG_WET, mma_pkg::LVL_W'(w));
			write_level(mma_pkg::REG_DRY, mma_pkg::LVL_W'(d));
			calm = (ph == 2) || (ph == PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 9) == 0)
					ch = $urandom_range(mma_pkg::CHANNELS, 7);
				else
					ch = $urandom_range(0, mma_pkg::CHANNELS - 1);
				send_request(ch, pick_sample(), 1'b0, want);
			end
		end

		// Drain, then watch for stray results
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("multichannel_moving_average_percent_tb: clean");
		else
			$display("multichannel_moving_average_percent_tb: errors");
		$finish;
	end

endmodule
